// ----- hdl/lrupfr_pkg.sv -----
// Shared types and constants for the LRU page frame replacement unit.
package lrupfr_pkg;

   // Number of page frames and width of each frame's age counter.
   localparam int FRAMES = 4;
   localparam int AGE_WIDTH = 16;

   // Fixed field widths.
   localparam int PAGE_WIDTH = 16;
   localparam int OUT_IDX_WIDTH = 2;

   // Width of a frame index.
   localparam int IDX_WIDTH = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   typedef logic [IDX_WIDTH-1:0] idx_type;
   typedef logic [AGE_WIDTH-1:0] age_type;
   typedef logic [PAGE_WIDTH-1:0] page_type;

   // Index of the last frame visited by the scan.
   localparam idx_type LAST_IDX = idx_type'(FRAMES - 1);

   // Saturation value of an age counter.
   localparam age_type AGE_MAX = {AGE_WIDTH{1'b1}};

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    load;     // capture the page and clear the scan results
      logic    scan;     // examine the frame at scan_idx
      idx_type scan_idx; // frame under examination
      logic    commit;   // update the frames and register the result
   } ctrl_type;

endpackage

// ----- hdl/lrupfr_datapath.sv -----
// Frame table, scan logic and result registers of the LRU replacement unit.
module lrupfr_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lrupfr_pkg::ctrl_type                     ctrl,
   input  logic [lrupfr_pkg::PAGE_WIDTH-1:0]        req_page_number,
   output logic                                     rsp_loaded,
   output logic [lrupfr_pkg::OUT_IDX_WIDTH-1:0]     rsp_frame_index
);

   // Frame table: page numbers have no reset, ages reset to empty.
   lrupfr_pkg::page_type frame_page_ff [lrupfr_pkg::FRAMES];
   lrupfr_pkg::age_type  frame_age_ff  [lrupfr_pkg::FRAMES];

   // Page under lookup and the scan results gathered so far.
   lrupfr_pkg::page_type page_ff;
   logic                 hit_found_ff,   hit_found_in;
   logic                 empty_found_ff, empty_found_in;
   lrupfr_pkg::idx_type  hit_idx_ff,     hit_idx_in;
   lrupfr_pkg::idx_type  empty_idx_ff,   empty_idx_in;
   lrupfr_pkg::idx_type  oldest_idx_ff,  oldest_idx_in;
   lrupfr_pkg::age_type  oldest_ff,      oldest_in;

   // Result registers.
   logic                                 loaded_ff;
   logic [lrupfr_pkg::OUT_IDX_WIDTH-1:0] frame_index_ff;

   lrupfr_pkg::age_type  scan_age;
   lrupfr_pkg::page_type scan_page;
   logic                 scan_occupied;
   lrupfr_pkg::idx_type  victim;
   logic [lrupfr_pkg::IDX_WIDTH+lrupfr_pkg::OUT_IDX_WIDTH-1:0] victim_wide;

   // Read the frame selected by the scan counter.
   assign scan_age      = frame_age_ff[ctrl.scan_idx];
   assign scan_page     = frame_page_ff[ctrl.scan_idx];
   assign scan_occupied = (scan_age != '0);

   // Fold one frame into the hit, empty and oldest searches.
   always_comb begin
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      empty_found_in = empty_found_ff;
      empty_idx_in   = empty_idx_ff;
      oldest_in      = oldest_ff;
      oldest_idx_in  = oldest_idx_ff;
      if (ctrl.load) begin
         hit_found_in   = 1'b0;
         empty_found_in = 1'b0;
         oldest_in      = '0;
         oldest_idx_in  = '0;
      end else if (ctrl.scan) begin
         if (!hit_found_ff && scan_occupied && (scan_page == page_ff)) begin
            hit_found_in = 1'b1;
            hit_idx_in   = ctrl.scan_idx;
         end
         if (!empty_found_ff && !scan_occupied) begin
            empty_found_in = 1'b1;
            empty_idx_in   = ctrl.scan_idx;
         end
         // Strict compare keeps the lowest index among equal ages.
         if (scan_occupied && (scan_age > oldest_ff)) begin
            oldest_in     = scan_age;
            oldest_idx_in = ctrl.scan_idx;
         end
      end
   end

   // A hit wins, then the first empty frame, then the oldest frame.
   always_comb begin
      if (hit_found_ff) begin
         victim = hit_idx_ff;
      end else if (empty_found_ff) begin
         victim = empty_idx_ff;
      end else begin
         victim = oldest_idx_ff;
      end
   end

   assign victim_wide = {{lrupfr_pkg::OUT_IDX_WIDTH{1'b0}}, victim};

   // Scan flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
      end else begin
         hit_found_ff   <= hit_found_in;
         empty_found_ff <= empty_found_in;
      end
   end

   // Scan payload registers.
   always_ff @(posedge clock) begin
      hit_idx_ff    <= hit_idx_in;
      empty_idx_ff  <= empty_idx_in;
      oldest_ff     <= oldest_in;
      oldest_idx_ff <= oldest_idx_in;
      if (ctrl.load) begin
         page_ff <= req_page_number;
      end
   end

   // Age update: the chosen frame restarts at one, other occupied frames
   // age by one and saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < lrupfr_pkg::FRAMES; f++) begin
            frame_age_ff[f] <= '0;
         end
      end else if (ctrl.commit) begin
         for (int f = 0; f < lrupfr_pkg::FRAMES; f++) begin
            if (lrupfr_pkg::idx_type'(f) == victim) begin
               frame_age_ff[f] <= lrupfr_pkg::age_type'(1);
            end else if ((frame_age_ff[f] != '0) &&
                         (frame_age_ff[f] != lrupfr_pkg::AGE_MAX)) begin
               frame_age_ff[f] <= frame_age_ff[f] + lrupfr_pkg::age_type'(1);
            end
         end
      end
   end

   // Page load on a miss.
   always_ff @(posedge clock) begin
      if (ctrl.commit && !hit_found_ff) begin
         frame_page_ff[victim] <= page_ff;
      end
   end

   // Result registers, loaded with the frame update.
   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         loaded_ff      <= !hit_found_ff;
         frame_index_ff <= victim_wide[lrupfr_pkg::OUT_IDX_WIDTH-1:0];
      end
   end

   assign rsp_loaded      = loaded_ff;
   assign rsp_frame_index = frame_index_ff;

endmodule

// ----- hdl/lrupfr_controller.sv -----
// Sequencing state machine of the LRU replacement unit.
module lrupfr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output lrupfr_pkg::ctrl_type ctrl
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   lrupfr_pkg::idx_type scan_idx_ff, scan_idx_in;
   logic                valid_ff;
   logic                accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Next state and scan counter.
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff == lrupfr_pkg::LAST_IDX) begin
               state_in = ST_UPDATE;
            end else begin
               scan_idx_in = scan_idx_ff + lrupfr_pkg::idx_type'(1);
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         valid_ff    <= (state_ff == ST_UPDATE);
      end
   end

   // Commands to the datapath.
   always_comb begin
      ctrl.load     = accept;
      ctrl.scan     = (state_ff == ST_SCAN);
      ctrl.scan_idx = scan_idx_ff;
      ctrl.commit   = (state_ff == ST_UPDATE);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- hdl/lru_page_frame_replacement_unit.sv -----
// Top level of the LRU page frame replacement unit.
//
// Channel    Ports                                   Transfer when
// request    start, busy, req_page_number            start && !busy at a clock edge
// response   rsp_valid, rsp_loaded, rsp_frame_index  rsp_valid high for one cycle
//
// Each reference goes through these steps in order: the page is captured when the
// request is accepted, the scan visits every frame over the single frame-table read
// port, and the ages are updated; the result strobes in the cycle after the update.
// A new reference is accepted while the previous result is on the outputs.
// Synchronous reset empties all frames; no clearing pass is needed.
// The receiver cannot stall the response.
module lru_page_frame_replacement_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [lrupfr_pkg::PAGE_WIDTH-1:0]    req_page_number,
   output logic                                 rsp_valid,
   output logic                                 rsp_loaded,
   output logic [lrupfr_pkg::OUT_IDX_WIDTH-1:0] rsp_frame_index
);

   lrupfr_pkg::ctrl_type ctrl;

   // Sequencer.
   lrupfr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   // Frame table and scan logic.
   lrupfr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_page_number (req_page_number),
      .rsp_loaded      (rsp_loaded),
      .rsp_frame_index (rsp_frame_index)
   );

endmodule

// ----- test/lru_page_frame_replacement_unit_test.sv -----
// Testbench for the LRU page frame replacement unit with a scoreboard of frame placements.
`timescale 1ns / 1ps

module lru_page_frame_replacement_unit_test;

   localparam int RANDOM_REFERENCES = 1600;
   localparam int DRAIN_LIMIT = 200;

   typedef logic [lrupfr_pkg::OUT_IDX_WIDTH-1:0] out_idx_type;

   // One expected response: hit or load, and the frame that holds the page.
   typedef struct packed {
      logic        loaded;
      out_idx_type frame_index;
   } placement_type;

   // Tracks frame contents and ages and holds the placements still to come.
   class frame_placement_scoreboard;
      lrupfr_pkg::page_type frame_page[lrupfr_pkg::FRAMES];
      lrupfr_pkg::age_type  frame_age[lrupfr_pkg::FRAMES];
      placement_type        expected_placements[$];
      int                   mismatches;

      function new();
         foreach (frame_age[f]) begin
            frame_age[f] = '0;
            frame_page[f] = '0;
         end
         mismatches = 0;
      endfunction

      // Every occupied frame except the one just used ages by one, up to the ceiling.
      function void age_other_frames(int keep);
         foreach (frame_age[f]) begin
            if (f != keep && frame_age[f] != '0 && frame_age[f] != lrupfr_pkg::AGE_MAX) begin
               frame_age[f] = frame_age[f] + lrupfr_pkg::age_type'(1);
            end
         end
      endfunction

      // Works out where an accepted reference ends up and queues that placement.
      function void note_reference(lrupfr_pkg::page_type page);
         int                  hit_frame;
         int                  victim;
         lrupfr_pkg::age_type oldest;
         placement_type       placement;
         hit_frame = -1;
         victim = -1;
         oldest = '0;
         // Only occupied frames take part in the compare; the lowest index wins.
         foreach (frame_age[f]) begin
            if (hit_frame < 0 && frame_age[f] != '0 && frame_page[f] == page) begin
               hit_frame = f;
            end
         end
         if (hit_frame >= 0) begin
            frame_age[hit_frame] = lrupfr_pkg::age_type'(1);
            age_other_frames(hit_frame);
            placement.loaded = 1'b0;
            placement.frame_index = out_idx_type'(hit_frame);
         end else begin
            // First empty frame, else the first frame with the greatest age.
            foreach (frame_age[f]) begin
               if (victim < 0 || frame_age[victim] != '0) begin
                  if (frame_age[f] == '0) begin
                     victim = f;
                  end else if (victim < 0 || frame_age[f] > oldest) begin
                     oldest = frame_age[f];
                     victim = f;
                  end
               end
            end
            frame_page[victim] = page;
            frame_age[victim] = lrupfr_pkg::age_type'(1);
            age_other_frames(victim);
            placement.loaded = 1'b1;
            placement.frame_index = out_idx_type'(victim);
         end
         expected_placements.push_back(placement);
      endfunction

      function void report_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch at %0t ns: %s", $time, what);
         end
      endfunction

      // Compares one response transfer with the oldest expected placement.
      function void check_placement(logic loaded, out_idx_type frame_index);
         placement_type want;
         if (expected_placements.size() == 0) begin
            report_mismatch($sformatf("unexpected response loaded=%0b frame=%0d",
                                      loaded, frame_index));
            return;
         end
         want = expected_placements.pop_front();
         if (loaded !== want.loaded || frame_index !== want.frame_index) begin
            report_mismatch($sformatf("expected loaded=%0b frame=%0d, got loaded=%0b frame=%0d",
                                      want.loaded, want.frame_index, loaded, frame_index));
         end
      endfunction

      function int pending();
         return expected_placements.size();
      endfunction

      function int failures();
         return mismatches + expected_placements.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   lrupfr_pkg::page_type req_page_number;
   logic                 rsp_valid;
   logic                 rsp_loaded;
   out_idx_type          rsp_frame_index;

   frame_placement_scoreboard placements = new();

   lru_page_frame_replacement_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_loaded      (rsp_loaded),
      .rsp_frame_index (rsp_frame_index)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, far beyond the length of a normal run.
   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one reference from a falling edge and holds it until the transfer.
   // Returns at the next falling edge with start still high.
   task automatic send_reference(lrupfr_pkg::page_type page);
      start = 1'b1;
      req_page_number = page;
      do begin
         @(posedge clock);
      end while (busy);
      placements.note_reference(page);
      @(negedge clock);
   endtask

   // Drops start for a number of cycles, with noise on the page bus.
   task automatic idle_sender(int cycles);
      repeat (cycles) begin
         start = 1'b0;
         req_page_number = lrupfr_pkg::page_type'($urandom);
         @(negedge clock);
      end
   endtask

   // Every response transfer is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         placements.check_placement(rsp_loaded, rsp_frame_index);
      end
   end

   initial begin
      lrupfr_pkg::page_type directed_pages[$];
      lrupfr_pkg::page_type page_pool[8];
      int                   pool_size;
      int                   burst;
      int                   sent;
      int                   waited;

      reset = 1'b1;
      start = 1'b0;
      req_page_number = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_sender(2);

      // Directed: page zero into empty frames, extremes, hits, eviction order, repeats.
      directed_pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A, 16'hFFFF,
                         16'h1234, 16'h0000, 16'h0001, 16'h8000, 16'h8000, 16'h8000,
                         16'h7FFF, 16'hFFFE, 16'hA5A5, 16'h1234, 16'h5A5A, 16'h0001,
                         16'h5A5A};
      foreach (directed_pages[i]) begin
         send_reference(directed_pages[i]);
         if (i % 3 == 2) begin
            idle_sender(i % 5);
         end
      end
      idle_sender(3);

      // Random bursts drawn mostly from a small page pool so hits and evictions mix.
      sent = 0;
      while (sent < RANDOM_REFERENCES) begin
         if ($urandom_range(0, 3) == 0) begin
            foreach (page_pool[i]) page_pool[i] = lrupfr_pkg::page_type'($urandom);
         end
         pool_size = $urandom_range(3, 8);
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 15) begin
               send_reference(lrupfr_pkg::page_type'($urandom));
            end else begin
               send_reference(page_pool[$urandom_range(0, pool_size - 1)]);
            end
            sent++;
         end
         if ($urandom_range(0, 4) != 0) begin
            idle_sender($urandom_range(1, 12));
         end
      end
      idle_sender(1);

      // Drain the outstanding responses, then keep watching for stray responses.
      waited = 0;
      while (placements.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);

      if (placements.failures() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- lru_page_frame_replacement_unit.f -----
hdl/lrupfr_pkg.sv
hdl/lrupfr_datapath.sv
hdl/lrupfr_controller.sv
hdl/lru_page_frame_replacement_unit.sv
test/lru_page_frame_replacement_unit_test.sv
